>>> hw/rtl/edd_pkg.sv
// Shared constants and types for the error diffusion dither block.
`default_nettype none
package edd_pkg;
	localparam int IMAGE_WIDTH_DEF = 320;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int GRAY_W          = 8;
	localparam int ERR_W           = 10;
	localparam int BYTE_W          = 8;
	localparam logic [BYTE_W-1:0] LEFT_BIT = 8'h80;

	typedef struct packed {
		logic frame_start;
		logic first_row;
		logic last;
		logic byte_end;
	} edd_ctrl_t;

	localparam int CTRL_W = $bits(edd_ctrl_t);
endpackage
`default_nettype wire

>>> hw/rtl/error_diffusion_dither.sv
// Error diffusion dither top level: 8-bit gray in, packed 1-bit pixels out.
//
// Input stream: one gray pixel per beat in raster order, IMAGE_WIDTH pixels
// per row. tuser high marks the first pixel of a frame; it restarts the
// column count and clears all carried error, also in the middle of a row
// (a partly built byte is dropped).
// Output stream: one byte per eight pixels, leftmost pixel in bit 7, 1 = white.
// tlast marks the byte that ends a row; a short last byte is left-aligned
// with zero padding.
// Throughput: one pixel per cycle while the output is not stalled, set by
// the quantize and right-carry loop in the back end; the error line memory
// takes one read and one write per cycle.
// Path: the last pixel of a byte is registered in the queue, then in the
// stage-one register, then in the output register that drives m_tdata.
// A four-entry queue sits between the input tagging and the back end; when
// the receiver stalls, pixels that complete no byte keep flowing until the
// output register and then the queue fill, after which s_tready drops.
// Reset: the column count restarts and the first row reads zero error.
// The error line is not swept; it needs no clearing pass.
`default_nettype none
module error_diffusion_dither #(
	parameter int IMAGE_WIDTH = edd_pkg::IMAGE_WIDTH_DEF,
	parameter int QUEUE_DEPTH = edd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [edd_pkg::GRAY_W-1:0] s_tdata,   // [7:0] gray
	input  wire logic                       s_tuser,   // [0] frame_start
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [edd_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] packed_byte
	output logic                            m_tlast    // end_of_row
);
	localparam int COL_W = $clog2(IMAGE_WIDTH);
	localparam int Q_W   = edd_pkg::GRAY_W + COL_W + edd_pkg::CTRL_W;

	logic                       push_valid, push_ready;
	logic [edd_pkg::GRAY_W-1:0] push_gray;
	logic [COL_W-1:0]           push_col;
	edd_pkg::edd_ctrl_t         push_ctrl;
	logic                       pop_valid, pop_ready;
	logic [Q_W-1:0]             pop_data;
	logic [edd_pkg::GRAY_W-1:0] pop_gray;
	logic [COL_W-1:0]           pop_col;
	edd_pkg::edd_ctrl_t         pop_ctrl;

	edd_front #(
		.IMAGE_WIDTH(IMAGE_WIDTH),
		.COL_W      (COL_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_gray (push_gray),
		.push_col  (push_col),
		.push_ctrl (push_ctrl)
	);

	edd_queue #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_ctrl, push_col, push_gray}),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	assign pop_gray = pop_data[edd_pkg::GRAY_W-1:0];
	assign pop_col  = pop_data[edd_pkg::GRAY_W +: COL_W];
	assign pop_ctrl = pop_data[Q_W-1 -: edd_pkg::CTRL_W];

	edd_back #(
		.IMAGE_WIDTH(IMAGE_WIDTH),
		.COL_W      (COL_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_gray (pop_gray),
		.pop_col  (pop_col),
		.pop_ctrl (pop_ctrl),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);
endmodule
`default_nettype wire

>>> hw/rtl/edd_front.sv
// Input side: accepts pixels, tracks column and row, tags each pixel.
`default_nettype none
module edd_front #(
	parameter int IMAGE_WIDTH = edd_pkg::IMAGE_WIDTH_DEF,
	parameter int COL_W       = $clog2(IMAGE_WIDTH)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [edd_pkg::GRAY_W-1:0] s_tdata,   // [7:0] gray
	input  wire logic                       s_tuser,   // [0] frame_start
	output logic                            push_valid,
	input  wire logic                       push_ready,
	output logic [edd_pkg::GRAY_W-1:0]      push_gray,
	output logic [COL_W-1:0]                push_col,
	output edd_pkg::edd_ctrl_t              push_ctrl
);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(IMAGE_WIDTH - 1);

	logic [COL_W-1:0] col_q;
	logic             first_row_q;
	logic [COL_W-1:0] col;
	logic             first_row;
	logic             accept;

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;
	assign accept     = s_tvalid && push_ready;

	assign col       = s_tuser ? '0 : col_q;
	assign first_row = s_tuser ? 1'b1 : first_row_q;

	assign push_gray             = s_tdata;
	assign push_col              = col;
	assign push_ctrl.frame_start = s_tuser;
	assign push_ctrl.first_row   = first_row;
	assign push_ctrl.last        = (col == LAST_COL);
	assign push_ctrl.byte_end    = (col[2:0] == 3'd7) || (col == LAST_COL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			if (col == LAST_COL) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q       <= col + 1'b1;
				first_row_q <= first_row;
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/edd_queue.sv
// Small FIFO between the tagging front and the diffusion back end.
`default_nettype none
module edd_queue #(
	parameter int DEPTH = edd_pkg::QUEUE_DEPTH_DEF,
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/edd_back.sv
// Diffusion engine: error line memory, quantizer, bit packer, output register.
`default_nettype none
module edd_back #(
	parameter int IMAGE_WIDTH = edd_pkg::IMAGE_WIDTH_DEF,
	parameter int COL_W       = $clog2(IMAGE_WIDTH)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       pop_valid,
	output logic                            pop_ready,
	input  wire logic [edd_pkg::GRAY_W-1:0] pop_gray,
	input  wire logic [COL_W-1:0]           pop_col,
	input  wire edd_pkg::edd_ctrl_t         pop_ctrl,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [edd_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] packed_byte
	output logic                            m_tlast    // end_of_row
);
	localparam int ERR_W = edd_pkg::ERR_W;
	localparam int BW    = edd_pkg::BYTE_W;
	localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(IMAGE_WIDTH - 1);

	// error line, entry m holds the error for column m of the row below
	logic signed [ERR_W-1:0] line_mem [IMAGE_WIDTH];

	logic                         valid_s1;
	logic [edd_pkg::GRAY_W-1:0]   gray_s1;
	logic [COL_W-1:0]             col_s1;
	edd_pkg::edd_ctrl_t           ctrl_s1;
	logic signed [ERR_W-1:0]      err_s1;

	logic signed [ERR_W-1:0] rc_q, sn_q, sf_q;
	logic [BW-1:0]           bits_q;
	logic                    pend_q;
	logic signed [ERR_W-1:0] pend_data_q;

	logic                    out_valid_q;
	logic [BW-1:0]           out_data_q;
	logic                    out_last_q;

	logic signed [ERR_W-1:0] rc_cur, sn_cur, sf_cur;
	logic [BW-1:0]           bits_cur, bits_new;
	logic signed [10:0]      v_raw;
	logic [7:0]              v8;
	logic                    white;
	logic signed [11:0]      e12, t7, t3, t5, s7, s3, s5, s1;
	logic signed [ERR_W-1:0] d7, d3, d5, d1, near_new;
	logic                    adv_s1;
	logic                    load_s1;
	logic                    wr_en;
	logic [COL_W-1:0]        wr_addr;
	logic signed [ERR_W-1:0] wr_data;

	assign rc_cur   = ctrl_s1.frame_start ? '0 : rc_q;
	assign sn_cur   = ctrl_s1.frame_start ? '0 : sn_q;
	assign sf_cur   = ctrl_s1.frame_start ? '0 : sf_q;
	assign bits_cur = ctrl_s1.frame_start ? '0 : bits_q;

	always_comb begin
		v_raw = $signed({3'b000, gray_s1}) + $signed({err_s1[ERR_W-1], err_s1})
			+ $signed({rc_cur[ERR_W-1], rc_cur});
		if (v_raw[10]) begin
			v8 = 8'd0;
		end else if (v_raw[9:8] != 2'b00) begin
			v8 = 8'd255;
		end else begin
			v8 = v_raw[7:0];
		end
		white = v8[7];
		e12   = white ? ($signed({4'b0000, v8}) - 12'sd255) : $signed({4'b0000, v8});
		t7    = (e12 <<< 3) - e12;
		t3    = (e12 <<< 1) + e12;
		t5    = (e12 <<< 2) + e12;
		s7    = t7 >>> 4;
		s3    = t3 >>> 4;
		s5    = t5 >>> 4;
		s1    = e12 >>> 4;
		d7    = s7[ERR_W-1:0];
		d3    = s3[ERR_W-1:0];
		d5    = s5[ERR_W-1:0];
		d1    = s1[ERR_W-1:0];
		near_new = sf_cur + d5;
		bits_new = bits_cur | (white ? (edd_pkg::LEFT_BIT >> col_s1[2:0]) : '0);
	end

	assign adv_s1    = valid_s1 && (!ctrl_s1.byte_end || !out_valid_q || m_tready);
	assign load_s1   = !valid_s1 || adv_s1;
	assign pop_ready = load_s1;

	// lower-left term of column c lands in entry c-1; the last column also
	// leaves the lower term for the final entry, written in the cycle after it from pend_data_q
	assign wr_en   = pend_q || (adv_s1 && (col_s1 != '0));
	assign wr_addr = pend_q ? LAST_ADDR : col_s1 - 1'b1;
	assign wr_data = pend_q ? pend_data_q : (sn_cur + d3);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && pop_valid) begin
			gray_s1 <= pop_gray;
			col_s1  <= pop_col;
			ctrl_s1 <= pop_ctrl;
			err_s1  <= pop_ctrl.first_row ? '0 : line_mem[pop_col];
		end
		if (adv_s1 && ctrl_s1.last) begin
			pend_data_q <= near_new;
		end
		if (adv_s1 && ctrl_s1.byte_end) begin
			out_data_q <= bits_new;
			out_last_q <= ctrl_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rc_q        <= '0;
			sn_q        <= '0;
			sf_q        <= '0;
			bits_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= pop_valid;
			end
			pend_q <= adv_s1 && ctrl_s1.last;
			if (adv_s1) begin
				if (ctrl_s1.last) begin
					rc_q <= '0;
					sn_q <= '0;
					sf_q <= '0;
				end else begin
					rc_q <= d7;
					sn_q <= near_new;
					sf_q <= d1;
				end
				bits_q <= ctrl_s1.byte_end ? '0 : bits_new;
			end
			if (adv_s1 && ctrl_s1.byte_end) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
endmodule
`default_nettype wire

>>> hw/rtl/edd_checker.sv
// Port-level assertions for the dither block, bound to the top level.
`default_nettype none
module edd_checker #(
	parameter int IMAGE_WIDTH = edd_pkg::IMAGE_WIDTH_DEF
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic [edd_pkg::GRAY_W-1:0] s_tdata,
	input wire logic                       s_tuser,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [edd_pkg::BYTE_W-1:0] m_tdata,
	input wire logic                       m_tlast
);
	localparam int TAIL = IMAGE_WIDTH % 8;
	localparam logic [edd_pkg::BYTE_W-1:0] PAD_MASK =
		(TAIL == 0) ? 8'h00 : (8'hFF >> TAIL);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input beat changed while stalled");

	a_row_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata & PAD_MASK) == 8'h00)
		else $error("row end beat has set padding bits");

	a_ready_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output beat right after reset");
endmodule

bind error_diffusion_dither edd_checker #(
	.IMAGE_WIDTH(IMAGE_WIDTH)
) u_edd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
`default_nettype wire
